/* sv/flqr_pkg.sv */
// shared types, constants and the recursion microprogram for the lqr controller
`default_nettype none

package flqr_pkg;

  localparam int unsigned MaxHorizonDef = 1024;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned NumRegs       = 32;
  localparam int unsigned DivSteps      = 64;

  // input and result words
  typedef struct packed {
    logic               func;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic [9:0]         step_index;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] acceleration;
    logic [2:0]         status;
  } out_word_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StStep     = 3'd1,
    StNotBuilt = 3'd2,
    StDenom    = 3'd3,
    StOvf      = 3'd4
  } status_e;

  // configuration registers
  typedef enum logic [2:0] {
    CfgTimeStep  = 3'd0,
    CfgHorizon   = 3'd1,
    CfgPosW      = 3'd2,
    CfgVelW      = 3'd3,
    CfgFinPosW   = 3'd4,
    CfgFinVelW   = 3'd5,
    CfgEffortW   = 3'd6,
    CfgAccelLim  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] time_step;
    logic [10:0] horizon_length;
    logic [30:0] pos_weight;
    logic [30:0] vel_weight;
    logic [30:0] final_pos_weight;
    logic [30:0] final_vel_weight;
    logic [30:0] effort_weight;
    logic [30:0] accel_limit;
  } cfg_t;

  // microprogram encoding
  typedef enum logic [2:0] {
    OpLd, OpMul, OpAdd, OpSub, OpDiv, OpPq, OpChk, OpStore
  } op_e;

  typedef enum logic [3:0] {
    SrcHalf, SrcTwo, SrcDt, SrcPosW, SrcVelW, SrcEffW, SrcFinPos, SrcFinVel, SrcZero
  } src_e;

  typedef enum logic [4:0] {
    RHalf, RTwo, RDt, RQp, RQv, RRw, RP00, RP01, RP11, RT1, RT2, RB0, RDt2,
    RTwoDt, RB00, RB01, RB11, RR0, RR1, RP00Dt, RP01Dt, RA01, RA11, RDen, RK0, RK1
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e dst;
    reg_e a;
    reg_e b;
    src_e src;
  } instr_t;

  typedef enum logic [2:0] {
    WbLd, WbAdd, WbSub, WbMul, WbDiv
  } wsel_e;

  // controller to datapath
  typedef struct packed {
    logic  rd;
    reg_e  a;
    reg_e  b;
    logic  wr;
    wsel_e wsel;
    reg_e  dst;
    src_e  src;
    logic  mul;
    logic  div_start;
    logic  div_pq;
    logic  store;
    logic  grd;
    logic  q_m0;
    logic  q_m1;
    logic  q_sum;
    logic  q_acc;
    logic  clr;
    logic  ld_in;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic               den_nonpos;
    logic               div_done;
    logic               ovf;
    logic signed [31:0] acc;
  } dp_stat_t;

  typedef enum logic [3:0] {
    CsIdle, CsRd, CsEx, CsMw, CsDs, CsDw, CsQr, CsQ0, CsQ1, CsQ2, CsQ3, CsOut
  } ctrl_state_e;

  localparam logic [5:0] ProgLast  = 6'd48;
  localparam logic [5:0] BodyStart = 6'd17;

  // true when a wide value leaves the signed 32-bit range
  function automatic logic oor32(input logic signed [63:0] v);
    return !((&v[63:31]) || !(|v[63:31]));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (oor32(v)) begin
      r = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic instr_t mk(input op_e op, input reg_e dst, input reg_e a,
                                input reg_e b, input src_e src);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.a   = a;
    i.b   = b;
    i.src = src;
    return i;
  endfunction

  // setup of the step constants, then one backward riccati step
  function automatic instr_t prog(input logic [5:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(OpLd,  RHalf,  RHalf,  RHalf,  SrcHalf);
      6'd1:  i = mk(OpLd,  RTwo,   RHalf,  RHalf,  SrcTwo);
      6'd2:  i = mk(OpLd,  RDt,    RHalf,  RHalf,  SrcDt);
      6'd3:  i = mk(OpLd,  RQp,    RHalf,  RHalf,  SrcPosW);
      6'd4:  i = mk(OpLd,  RQv,    RHalf,  RHalf,  SrcVelW);
      6'd5:  i = mk(OpLd,  RRw,    RHalf,  RHalf,  SrcEffW);
      6'd6:  i = mk(OpLd,  RP00,   RHalf,  RHalf,  SrcFinPos);
      6'd7:  i = mk(OpLd,  RP01,   RHalf,  RHalf,  SrcZero);
      6'd8:  i = mk(OpLd,  RP11,   RHalf,  RHalf,  SrcFinVel);
      6'd9:  i = mk(OpMul, RT1,    RHalf,  RDt,    SrcZero);
      6'd10: i = mk(OpMul, RB0,    RT1,    RDt,    SrcZero);
      6'd11: i = mk(OpMul, RDt2,   RDt,    RDt,    SrcZero);
      6'd12: i = mk(OpMul, RTwoDt, RTwo,   RDt,    SrcZero);
      6'd13: i = mk(OpMul, RB00,   RB0,    RB0,    SrcZero);
      6'd14: i = mk(OpMul, RT1,    RTwo,   RB0,    SrcZero);
      6'd15: i = mk(OpMul, RB01,   RT1,    RDt,    SrcZero);
      6'd16: i = mk(OpMul, RB11,   RDt,    RDt,    SrcZero);
      6'd17: i = mk(OpMul, RT1,    RB0,    RP00,   SrcZero);
      6'd18: i = mk(OpMul, RT2,    RDt,    RP01,   SrcZero);
      6'd19: i = mk(OpAdd, RR0,    RT1,    RT2,    SrcZero);
      6'd20: i = mk(OpMul, RP00Dt, RP00,   RDt,    SrcZero);
      6'd21: i = mk(OpMul, RP01Dt, RP01,   RDt,    SrcZero);
      6'd22: i = mk(OpAdd, RA01,   RP00Dt, RP01,   SrcZero);
      6'd23: i = mk(OpMul, RT1,    RB0,    RA01,   SrcZero);
      6'd24: i = mk(OpAdd, RT2,    RP01Dt, RP11,   SrcZero);
      6'd25: i = mk(OpMul, RT2,    RDt,    RT2,    SrcZero);
      6'd26: i = mk(OpAdd, RR1,    RT1,    RT2,    SrcZero);
      6'd27: i = mk(OpMul, RT1,    RB00,   RP00,   SrcZero);
      6'd28: i = mk(OpAdd, RDen,   RRw,    RT1,    SrcZero);
      6'd29: i = mk(OpMul, RT1,    RB01,   RP01,   SrcZero);
      6'd30: i = mk(OpAdd, RDen,   RDen,   RT1,    SrcZero);
      6'd31: i = mk(OpMul, RT1,    RB11,   RP11,   SrcZero);
      6'd32: i = mk(OpAdd, RDen,   RDen,   RT1,    SrcZero);
      6'd33: i = mk(OpChk, RT1,    RDen,   RDen,   SrcZero);
      6'd34: i = mk(OpDiv, RK0,    RR0,    RR0,    SrcZero);
      6'd35: i = mk(OpDiv, RK1,    RR1,    RR1,    SrcZero);
      6'd36: i = mk(OpStore, RT1,  RK0,    RK1,    SrcZero);
      6'd37: i = mk(OpMul, RT1,    RDt2,   RP00,   SrcZero);
      6'd38: i = mk(OpMul, RT2,    RTwoDt, RP01,   SrcZero);
      6'd39: i = mk(OpAdd, RT1,    RT1,    RT2,    SrcZero);
      6'd40: i = mk(OpAdd, RA11,   RT1,    RP11,   SrcZero);
      6'd41: i = mk(OpAdd, RT1,    RQp,    RP00,   SrcZero);
      6'd42: i = mk(OpPq,  RT2,    RR0,    RR0,    SrcZero);
      6'd43: i = mk(OpSub, RP00,   RT1,    RT2,    SrcZero);
      6'd44: i = mk(OpPq,  RT2,    RR0,    RR1,    SrcZero);
      6'd45: i = mk(OpSub, RP01,   RA01,   RT2,    SrcZero);
      6'd46: i = mk(OpAdd, RT1,    RQv,    RA11,   SrcZero);
      6'd47: i = mk(OpPq,  RT2,    RR1,    RR1,    SrcZero);
      6'd48: i = mk(OpSub, RP11,   RT1,    RT2,    SrcZero);
      default: i = mk(OpLd, RT1,   RHalf,  RHalf,  SrcZero);
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

/* sv/flqr_div.sv */
// radix-2 restoring divider, signed dividend by positive divisor, one bit per cycle
`default_nettype none

module flqr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic [31:0]        divisor_i,
  output logic               done_o,
  output logic signed [63:0] quotient_o
);
  import flqr_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     mag_q, mag_d;
  logic [32:0]     rem_q, rem_d;
  logic            neg_q, neg_d;
  logic [32:0]     rem_sh;
  logic            fits;

  // shift in the next dividend bit and try the subtract
  assign rem_sh = {rem_q[31:0], mag_q[63]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(DivSteps);
      neg_d = dividend_i[63];
      mag_d = dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
      rem_d = '0;
    end else if (run_q) begin
      rem_d = fits ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      mag_d = {mag_q[62:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

`default_nettype wire

/* sv/flqr_dp.sv */
// datapath: register file, multiplier, saturating adder, divider, gain table
`default_nettype none

module flqr_dp #(
  parameter int unsigned MAX_HORIZON = flqr_pkg::MaxHorizonDef,
  localparam int unsigned Aw = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flqr_pkg::cfg_t     cfg_i,
  input  flqr_pkg::in_word_t in_data_i,
  input  flqr_pkg::dp_cmd_t  cmd_i,
  input  logic [Aw-1:0]      gaddr_i,
  output flqr_pkg::dp_stat_t stat_o
);
  import flqr_pkg::*;

  logic signed [31:0] rf_q [NumRegs];
  logic [63:0]        gmem_q [MAX_HORIZON];

  logic signed [31:0] ra_q, rb_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] den_q;
  logic signed [31:0] pos_q, vel_q;
  logic [63:0]        gq_q;
  logic signed [31:0] t0_q, sum_q, acc_q;
  logic               ovf_q, ovf_d;

  logic signed [63:0] mul_sh, add_w, sub_w, sum_w, neg_w, dvd;
  logic signed [31:0] mul_r, src_val, wv, neg_r, lim, clamp_r;
  logic               wo;
  logic               div_done;
  logic signed [63:0] div_q;
  logic signed [31:0] g0, g1;

  // divider shared by the gain and update quotients
  assign dvd = cmd_i.div_pq ? prod_q : ({{32{ra_q[31]}}, ra_q} <<< FracBits);

  flqr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // fixed point arithmetic
  assign mul_sh = prod_q >>> FracBits;
  assign mul_r  = sat32(mul_sh);
  assign add_w  = {{32{ra_q[31]}}, ra_q} + {{32{rb_q[31]}}, rb_q};
  assign sub_w  = {{32{ra_q[31]}}, ra_q} - {{32{rb_q[31]}}, rb_q};
  assign sum_w  = {{32{t0_q[31]}}, t0_q} + {{32{mul_r[31]}}, mul_r};
  assign neg_w  = 64'sd0 - {{32{sum_q[31]}}, sum_q};
  assign neg_r  = sat32(neg_w);
  assign lim    = $signed({1'b0, cfg_i.accel_limit});
  assign g0     = $signed(gq_q[31:0]);
  assign g1     = $signed(gq_q[63:32]);

  always_comb begin
    if (neg_r > lim) begin
      clamp_r = lim;
    end else if (neg_r < -lim) begin
      clamp_r = -lim;
    end else begin
      clamp_r = neg_r;
    end
  end

  // load sources
  always_comb begin
    unique case (cmd_i.src)
      SrcHalf:   src_val = 32'(64'd1 << (FracBits - 1));
      SrcTwo:    src_val = 32'(64'd2 << FracBits);
      SrcDt:     src_val = $signed({1'b0, cfg_i.time_step});
      SrcPosW:   src_val = $signed({1'b0, cfg_i.pos_weight});
      SrcVelW:   src_val = $signed({1'b0, cfg_i.vel_weight});
      SrcEffW:   src_val = $signed({1'b0, cfg_i.effort_weight});
      SrcFinPos: src_val = $signed({1'b0, cfg_i.final_pos_weight});
      SrcFinVel: src_val = $signed({1'b0, cfg_i.final_vel_weight});
      default:   src_val = '0;
    endcase
  end

  // write-back select
  always_comb begin
    unique case (cmd_i.wsel)
      WbLd: begin
        wv = src_val;
        wo = 1'b0;
      end
      WbAdd: begin
        wv = sat32(add_w);
        wo = oor32(add_w);
      end
      WbSub: begin
        wv = sat32(sub_w);
        wo = oor32(sub_w);
      end
      WbMul: begin
        wv = mul_r;
        wo = oor32(mul_sh);
      end
      WbDiv: begin
        wv = sat32(div_q);
        wo = oor32(div_q);
      end
      default: begin
        wv = '0;
        wo = 1'b0;
      end
    endcase
  end

  // sticky overflow flag
  always_comb begin
    ovf_d = ovf_q;
    if (cmd_i.clr) begin
      ovf_d = 1'b0;
    end
    if (cmd_i.wr && wo) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.q_m1 && oor32(mul_sh)) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.q_sum && (oor32(mul_sh) || oor32(sum_w))) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.q_acc && oor32(neg_w)) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else begin
      ovf_q <= ovf_d;
    end
  end

  // register file, registered dual read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      rf_q[cmd_i.dst] <= wv;
    end
    if (cmd_i.rd) begin
      ra_q <= rf_q[cmd_i.a];
      rb_q <= rf_q[cmd_i.b];
    end
  end

  // gain table, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      gmem_q[gaddr_i] <= {rb_q, ra_q};
    end
    if (cmd_i.grd) begin
      gq_q <= gmem_q[gaddr_i];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (cmd_i.dst == RDen)) begin
      den_q <= wv;
    end
    if (cmd_i.ld_in) begin
      pos_q <= in_data_i.position;
      vel_q <= in_data_i.velocity;
    end
    if (cmd_i.mul) begin
      prod_q <= ra_q * rb_q;
    end else if (cmd_i.q_m0) begin
      prod_q <= g0 * pos_q;
    end else if (cmd_i.q_m1) begin
      prod_q <= g1 * vel_q;
    end
    if (cmd_i.q_m1) begin
      t0_q <= mul_r;
    end
    if (cmd_i.q_sum) begin
      sum_q <= sat32(sum_w);
    end
    if (cmd_i.clr) begin
      acc_q <= '0;
    end else if (cmd_i.q_acc) begin
      acc_q <= clamp_r;
    end
  end

  assign stat_o.den_nonpos = den_q <= 32'sd0;
  assign stat_o.div_done   = div_done;
  assign stat_o.ovf        = ovf_q;
  assign stat_o.acc        = acc_q;

endmodule

`default_nettype wire

/* sv/flqr_ctrl.sv */
// controller: sequences the recursion microprogram and control queries
`default_nettype none

module flqr_ctrl #(
  parameter int unsigned MAX_HORIZON = flqr_pkg::MaxHorizonDef,
  localparam int unsigned Aw = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1,
  localparam int unsigned Lw = $clog2(MAX_HORIZON + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [10:0]         horizon_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  flqr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output flqr_pkg::out_word_t out_data_o,
  output flqr_pkg::dp_cmd_t   cmd_o,
  output logic [Aw-1:0]       gaddr_o,
  input  flqr_pkg::dp_stat_t  stat_i
);
  import flqr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [5:0]    pc_q, pc_d;
  logic [Aw-1:0] k_q, k_d;
  logic          valid_q, valid_d;
  logic [Lw-1:0] blen_q, blen_d;
  status_e       status_q, status_d;
  logic          use_ovf_q, use_ovf_d;
  logic [9:0]    step_q, step_d;
  logic          ov_q, ov_d;
  out_word_t     out_q, out_d;
  instr_t        ins;
  logic          accept, bad_h, next_ins;
  status_e       fin_status;

  assign ins        = prog(pc_q);
  assign accept     = in_valid_i && (state_q == CsIdle);
  assign bad_h      = (horizon_i == 11'd0) || (32'(horizon_i) > 32'(MAX_HORIZON));
  assign fin_status = (use_ovf_q && stat_i.ovf) ? StOvf : status_q;

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    k_d       = k_q;
    valid_d   = valid_q;
    blen_d    = blen_q;
    status_d  = status_q;
    use_ovf_d = use_ovf_q;
    step_d    = step_q;
    ov_d      = ov_q;
    out_d     = out_q;
    next_ins  = 1'b0;
    cmd_o     = '0;
    cmd_o.a   = ins.a;
    cmd_o.b   = ins.b;
    cmd_o.dst = ins.dst;
    cmd_o.src = ins.src;

    // result word drains independently of the sequencer
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      CsIdle: begin
        if (accept) begin
          cmd_o.clr   = 1'b1;
          cmd_o.ld_in = 1'b1;
          use_ovf_d   = 1'b0;
          if (in_data_i.func) begin
            if (!valid_q) begin
              status_d = StNotBuilt;
              state_d  = CsOut;
            end else if (32'(in_data_i.step_index) >= 32'(blen_q)) begin
              status_d = StStep;
              state_d  = CsOut;
            end else begin
              step_d   = in_data_i.step_index;
              state_d  = CsQr;
            end
          end else if (bad_h) begin
            valid_d  = 1'b0;
            status_d = StStep;
            state_d  = CsOut;
          end else begin
            pc_d    = '0;
            k_d     = Aw'(horizon_i - 11'd1);
            state_d = CsRd;
          end
        end
      end
      CsRd: begin
        cmd_o.rd = 1'b1;
        state_d  = CsEx;
      end
      CsEx: begin
        unique case (ins.op)
          OpLd: begin
            cmd_o.wr   = 1'b1;
            cmd_o.wsel = WbLd;
            next_ins   = 1'b1;
          end
          OpAdd: begin
            cmd_o.wr   = 1'b1;
            cmd_o.wsel = WbAdd;
            next_ins   = 1'b1;
          end
          OpSub: begin
            cmd_o.wr   = 1'b1;
            cmd_o.wsel = WbSub;
            next_ins   = 1'b1;
          end
          OpMul: begin
            cmd_o.mul = 1'b1;
            state_d   = CsMw;
          end
          OpPq: begin
            cmd_o.mul = 1'b1;
            state_d   = CsDs;
          end
          OpDiv: begin
            cmd_o.div_start = 1'b1;
            state_d         = CsDw;
          end
          OpChk: begin
            if (stat_i.den_nonpos) begin
              valid_d  = 1'b0;
              status_d = StDenom;
              state_d  = CsOut;
            end else begin
              next_ins = 1'b1;
            end
          end
          OpStore: begin
            cmd_o.store = 1'b1;
            next_ins    = 1'b1;
          end
          default: state_d = CsIdle;
        endcase
      end
      CsMw: begin
        cmd_o.wr   = 1'b1;
        cmd_o.wsel = WbMul;
        next_ins   = 1'b1;
      end
      CsDs: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_pq    = 1'b1;
        state_d         = CsDw;
      end
      CsDw: begin
        if (stat_i.div_done) begin
          cmd_o.wr   = 1'b1;
          cmd_o.wsel = WbDiv;
          next_ins   = 1'b1;
        end
      end
      CsQr: begin
        cmd_o.grd = 1'b1;
        state_d   = CsQ0;
      end
      CsQ0: begin
        cmd_o.q_m0 = 1'b1;
        state_d    = CsQ1;
      end
      CsQ1: begin
        cmd_o.q_m1 = 1'b1;
        state_d    = CsQ2;
      end
      CsQ2: begin
        cmd_o.q_sum = 1'b1;
        state_d     = CsQ3;
      end
      CsQ3: begin
        cmd_o.q_acc = 1'b1;
        status_d    = StOk;
        use_ovf_d   = 1'b1;
        state_d     = CsOut;
      end
      CsOut: begin
        if (!ov_q || out_ready_i) begin
          out_d.acceleration = stat_i.acc;
          out_d.status       = fin_status;
          ov_d               = 1'b1;
          state_d            = CsIdle;
        end
      end
      default: state_d = CsIdle;
    endcase

    // advance the microprogram, closing the build after the last step
    if (next_ins) begin
      if (pc_q == ProgLast) begin
        if (k_q == '0) begin
          valid_d   = 1'b1;
          blen_d    = Lw'(horizon_i);
          status_d  = StOk;
          use_ovf_d = 1'b1;
          state_d   = CsOut;
        end else begin
          k_d     = k_q - 1'b1;
          pc_d    = BodyStart;
          state_d = CsRd;
        end
      end else begin
        pc_d    = pc_q + 6'd1;
        state_d = CsRd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CsIdle;
      pc_q      <= '0;
      k_q       <= '0;
      valid_q   <= 1'b0;
      blen_q    <= '0;
      status_q  <= StOk;
      use_ovf_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      k_q       <= k_d;
      valid_q   <= valid_d;
      blen_q    <= blen_d;
      status_q  <= status_d;
      use_ovf_q <= use_ovf_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    out_q  <= out_d;
  end

  assign gaddr_o     = (state_q == CsQr) ? Aw'(step_q) : k_q;
  assign in_ready_o  = state_q == CsIdle;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* sv/finite_horizon_lqr_controller_unit.sv */
// top level: configuration registers and the controller with its datapath
// control query: the gain read, two multiply passes, the sum and the clamp, in that order;
//   one query at a time
// build: its length is set by the divider run for each of the five quotients of a riccati
//   step and by the shared multiplier
// reset: all configuration registers take their defaults and the gain table is unbuilt
`default_nettype none

module finite_horizon_lqr_controller_unit #(
  parameter int unsigned MAX_HORIZON = flqr_pkg::MaxHorizonDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  flqr_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output flqr_pkg::out_word_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import flqr_pkg::*;

  localparam int unsigned Aw = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;

  cfg_t      cfg_q, cfg_d;
  cfg_idx_e  cidx;
  logic      cwr;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic [Aw-1:0] gaddr;

  assign cidx   = cfg_idx_e'(paddr[4:2]);
  assign cwr    = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cwr) begin
      unique case (cidx)
        CfgTimeStep: cfg_d.time_step        = pwdata[30:0];
        CfgHorizon:  cfg_d.horizon_length   = pwdata[10:0];
        CfgPosW:     cfg_d.pos_weight       = pwdata[30:0];
        CfgVelW:     cfg_d.vel_weight       = pwdata[30:0];
        CfgFinPosW:  cfg_d.final_pos_weight = pwdata[30:0];
        CfgFinVelW:  cfg_d.final_vel_weight = pwdata[30:0];
        CfgEffortW:  cfg_d.effort_weight    = pwdata[30:0];
        CfgAccelLim: cfg_d.accel_limit      = pwdata[30:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cidx)
      CfgTimeStep: prdata = {1'b0, cfg_q.time_step};
      CfgHorizon:  prdata = {21'd0, cfg_q.horizon_length};
      CfgPosW:     prdata = {1'b0, cfg_q.pos_weight};
      CfgVelW:     prdata = {1'b0, cfg_q.vel_weight};
      CfgFinPosW:  prdata = {1'b0, cfg_q.final_pos_weight};
      CfgFinVelW:  prdata = {1'b0, cfg_q.final_vel_weight};
      CfgEffortW:  prdata = {1'b0, cfg_q.effort_weight};
      CfgAccelLim: prdata = {1'b0, cfg_q.accel_limit};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step        <= 31'd65536;
      cfg_q.horizon_length   <= 11'd1;
      cfg_q.pos_weight       <= 31'd65536;
      cfg_q.vel_weight       <= 31'd65536;
      cfg_q.final_pos_weight <= 31'd65536;
      cfg_q.final_vel_weight <= 31'd65536;
      cfg_q.effort_weight    <= 31'd65536;
      cfg_q.accel_limit      <= 31'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  flqr_ctrl #(
    .MAX_HORIZON (MAX_HORIZON)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .horizon_i   (cfg_q.horizon_length),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .gaddr_o     (gaddr),
    .stat_i      (stat)
  );

  flqr_dp #(
    .MAX_HORIZON (MAX_HORIZON)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .gaddr_i   (gaddr),
    .stat_o    (stat)
  );

endmodule

`default_nettype wire

/* sv/flqr_checker.sv */
// port-level checks for the lqr controller, bound to the top level
`default_nettype none

module flqr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input flqr_pkg::out_word_t out_data_o,
  input logic                pready
);
  import flqr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // error answers carry no command
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StStep || out_data_o.status == StNotBuilt ||
                    out_data_o.status == StDenom) |-> out_data_o.acceleration == 32'sd0)
    else $error("nonzero acceleration with error status");

  // status codes stay within the defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StOk || out_data_o.status == StStep ||
                     out_data_o.status == StNotBuilt || out_data_o.status == StDenom ||
                     out_data_o.status == StOvf))
    else $error("undefined status code");

  // one word in flight: the input closes right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while busy");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind finite_horizon_lqr_controller_unit flqr_checker u_flqr_checker (.*);

`default_nettype wire
